### sv/ipdp_pkg.sv
// ----------------------------------------------------------------------------
// ipdp_pkg
// shared types, character codes and result record for the ipd frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package ipdp_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_LINK_REG   = 2'd1,
    KIND_TABLE_FULL = 2'd2,
    KIND_EMPTY      = 2'd3
  } kind_e;

  // request kinds
  typedef enum logic {
    OP_RX_BYTE  = 1'b0,
    OP_REG_LINK = 1'b1
  } op_e;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] DIGIT_MAX  = 8'd9;

  // link table entry: address in the upper bits, remote port below
  localparam int unsigned TBL_W = 48;

  // expected header word after the plus sign
  function automatic logic [7:0] hdr_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h49;  // I
      2'd1:    c = 8'h50;  // P
      2'd2:    c = 8'h44;  // D
      default: c = 8'h2C;  // comma
    endcase
    return c;
  endfunction

  // one result travelling down the pipe
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [3:0]  link_id;
    logic        link_valid;
    logic        use_tbl;
    logic [31:0] addr;
    logic [15:0] port;
    logic [15:0] frame_len;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

### sv/ipdp_ram.sv
// ----------------------------------------------------------------------------
// ipdp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ipdp_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### sv/ipdp_parser.sv
// ----------------------------------------------------------------------------
// ipdp_parser
// byte-wide frame parser and link registration, issues link table accesses
// ----------------------------------------------------------------------------
`default_nettype none

module ipdp_parser #(
  parameter int unsigned LINK_ENTRIES = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic                            op_i,
  input  wire logic [7:0]                      rx_byte_i,
  input  wire logic [31:0]                     link_addr_i,
  input  wire logic [15:0]                     link_rport_i,
  output ipdp_pkg::res_t                       res_o,
  output logic                                 ram_we_o,
  output logic      [$clog2(LINK_ENTRIES)-1:0] ram_waddr_o,
  output logic      [ipdp_pkg::TBL_W-1:0]      ram_wdata_o,
  output logic                                 ram_re_o,
  output logic      [$clog2(LINK_ENTRIES)-1:0] ram_raddr_o
);

  localparam int unsigned AW   = $clog2(LINK_ENTRIES);
  localparam int unsigned CntW = $clog2(LINK_ENTRIES + 1);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_MATCH = 3'd1,
    PH_DRAIN = 3'd2,
    PH_LINK  = 3'd3,
    PH_SKIP  = 3'd4,
    PH_LEN   = 3'd5,
    PH_DATA  = 3'd6
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [1:0]        match_pos_q, match_pos_d;
  logic [3:0]        cur_link_q, cur_link_d;
  logic              link_ok_q, link_ok_d;
  logic [15:0]       len_q, len_d;
  logic [15:0]       bytes_left_q, bytes_left_d;
  logic [CntW-1:0]   next_link_q, next_link_d;

  logic [7:0]        digit;
  logic              is_digit;
  logic              tbl_hit;
  logic              tbl_full;
  logic [15:0]       bl_dec;
  logic [15:0]       len_next;
  ipdp_pkg::res_t    res;

  always_comb begin
    phase_d      = phase_q;
    match_pos_d  = match_pos_q;
    cur_link_d   = cur_link_q;
    link_ok_d    = link_ok_q;
    len_d        = len_q;
    bytes_left_d = bytes_left_q;
    next_link_d  = next_link_q;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;

    digit    = rx_byte_i - ipdp_pkg::CHAR_ZERO;
    is_digit = (digit <= ipdp_pkg::DIGIT_MAX);
    tbl_hit  = link_ok_q && (CntW'(cur_link_q) < next_link_q);
    tbl_full = (next_link_q == CntW'(LINK_ENTRIES));
    bl_dec   = bytes_left_q - 16'd1;
    // times ten as two shifts
    len_next = {len_q[12:0], 3'b000} + {len_q[14:0], 1'b0} + {8'd0, digit};

    // frame result fields, kind and payload set per case
    res            = '0;
    res.kind       = ipdp_pkg::KIND_DATA;
    res.link_id    = cur_link_q;
    res.link_valid = link_ok_q;
    res.use_tbl    = tbl_hit;
    res.frame_len  = len_q;

    if (accept_i) begin
      if (op_i == ipdp_pkg::OP_REG_LINK) begin
        res       = '0;
        res.valid = 1'b1;
        if (tbl_full) begin
          res.kind = ipdp_pkg::KIND_TABLE_FULL;
        end else begin
          res.kind       = ipdp_pkg::KIND_LINK_REG;
          res.link_id    = next_link_q[3:0];
          res.link_valid = 1'b1;
          res.addr       = link_addr_i;
          res.port       = link_rport_i;
          ram_we_o       = 1'b1;
          next_link_d    = next_link_q + CntW'(1);
        end
      end else if (rx_byte_i != ipdp_pkg::CHAR_NUL) begin
        unique case (phase_q)
          PH_HUNT: begin
            if (rx_byte_i == ipdp_pkg::CHAR_PLUS) begin
              phase_d     = PH_MATCH;
              match_pos_d = 2'd0;
            end
          end
          PH_MATCH, PH_DRAIN: begin
            if (phase_q == PH_MATCH &&
                rx_byte_i != ipdp_pkg::hdr_char(match_pos_q)) begin
              phase_d = PH_DRAIN;
            end
            if (match_pos_q == 2'd3) begin
              phase_d     = (phase_d == PH_MATCH) ? PH_LINK : PH_HUNT;
              match_pos_d = 2'd0;
            end else begin
              match_pos_d = match_pos_q + 2'd1;
            end
          end
          PH_LINK: begin
            cur_link_d = digit[3:0];
            link_ok_d  = is_digit;
            phase_d    = PH_SKIP;
          end
          PH_SKIP: begin
            len_d   = 16'd0;
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            if (rx_byte_i == ipdp_pkg::CHAR_COLON) begin
              if (len_q == 16'd0) begin
                phase_d   = PH_HUNT;
                res.valid = 1'b1;
                res.kind  = ipdp_pkg::KIND_EMPTY;
                res.last  = 1'b1;
                ram_re_o  = tbl_hit;
              end else begin
                bytes_left_d = len_q;
                phase_d      = PH_DATA;
              end
            end else if (!is_digit) begin
              phase_d = PH_HUNT;
            end else begin
              len_d = len_next;
            end
          end
          PH_DATA: begin
            bytes_left_d  = bl_dec;
            res.valid     = 1'b1;
            res.data_byte = rx_byte_i;
            res.last      = (bl_dec == 16'd0);
            ram_re_o      = tbl_hit;
            if (bl_dec == 16'd0) begin
              phase_d = PH_HUNT;
            end
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end
    end
  end

  assign res_o       = res;
  assign ram_waddr_o = next_link_q[AW-1:0];
  assign ram_wdata_o = {link_addr_i, link_rport_i};
  assign ram_raddr_o = AW'(cur_link_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      match_pos_q  <= 2'd0;
      cur_link_q   <= 4'd0;
      link_ok_q    <= 1'b0;
      len_q        <= 16'd0;
      bytes_left_q <= 16'd0;
      next_link_q  <= '0;
    end else begin
      phase_q      <= phase_d;
      match_pos_q  <= match_pos_d;
      cur_link_q   <= cur_link_d;
      link_ok_q    <= link_ok_d;
      len_q        <= len_d;
      bytes_left_q <= bytes_left_d;
      next_link_q  <= next_link_d;
    end
  end

endmodule

`default_nettype wire

### sv/at_ipd_frame_parser_core.sv
// ----------------------------------------------------------------------------
// at_ipd_frame_parser_core
// receive-side parser for +IPD,<link>,<length>:<payload> modem frames with a
// link table of registered addresses and remote ports
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | to core   | in_valid_i / in_stall_o   | op, rx_byte, link_addr,
//          |           |                           | link_rport
//  out     | from core | out_valid_o / out_stall_i | kind, data_byte, link_id,
//          |           |                           | link_valid, src_addr, peer_port,
//          |           |                           | frame_len, last
//
//  one request per cycle is taken while in_stall_o is low; the parser state
//  updates in the cycle the request is accepted, and the link table is read or
//  written in that cycle; a result then passes the stage one register, beside
//  the registered ram read port, and then the output register
//  reset clears the parser, the fill count and the pipe valids; no clearing
//  pass is needed, entries at or above the fill count read as zero
//  a stalled output holds the pipe; requests keep flowing while either pipe
//  stage has room
// ----------------------------------------------------------------------------
`default_nettype none

module at_ipd_frame_parser_core #(
  parameter int unsigned LINK_ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [31:0] link_addr_i,
  input  wire logic [15:0] link_rport_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [1:0]  kind_o,
  output logic      [7:0]  data_byte_o,
  output logic      [3:0]  link_id_o,
  output logic             link_valid_o,
  output logic      [31:0] src_addr_o,
  output logic      [15:0] peer_port_o,
  output logic      [15:0] frame_len_o,
  output logic             last_o
);

  localparam int unsigned AW = $clog2(LINK_ENTRIES);

  // parser to table
  ipdp_pkg::res_t                res_new;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [ipdp_pkg::TBL_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [ipdp_pkg::TBL_W-1:0]    ram_rdata;

  // pipe stages
  logic                          s1_valid_q, s1_valid_d;
  ipdp_pkg::res_t                s1_q;
  ipdp_pkg::res_t                s1_merged;
  logic                          out_valid_q, out_valid_d;
  ipdp_pkg::res_t                out_q;

  logic                          in_accept;
  logic                          s1_adv;
  logic                          out_take;

  // output register frees when empty or when the result is taken
  assign out_take   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_take;
  assign in_stall_o = s1_valid_q && !out_take;
  assign in_accept  = in_valid_i && !in_stall_o;

  ipdp_parser #(
    .LINK_ENTRIES (LINK_ENTRIES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .op_i         (op_i),
    .rx_byte_i    (rx_byte_i),
    .link_addr_i  (link_addr_i),
    .link_rport_i (link_rport_i),
    .res_o        (res_new),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr)
  );

  // link table, address above remote port
  ipdp_ram #(
    .WIDTH (ipdp_pkg::TBL_W),
    .DEPTH (LINK_ENTRIES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // stage valids
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = res_new.valid;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // table data merged on the way out
  always_comb begin
    s1_merged = s1_q;
    if (s1_q.use_tbl) begin
      s1_merged.addr = ram_rdata[ipdp_pkg::TBL_W-1:16];
      s1_merged.port = ram_rdata[15:0];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= res_new;
    end
    if (s1_adv) begin
      out_q <= s1_merged;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign data_byte_o  = out_q.data_byte;
  assign link_id_o    = out_q.link_id;
  assign link_valid_o = out_q.link_valid;
  assign src_addr_o   = out_q.addr;
  assign peer_port_o  = out_q.port;
  assign frame_len_o  = out_q.frame_len;
  assign last_o       = out_q.last;

endmodule

`default_nettype wire

### sv/ipdp_checker.sv
// ----------------------------------------------------------------------------
// ipdp_checker
// port-level checks on the ipd frame parser results
// ----------------------------------------------------------------------------
`default_nettype none

module ipdp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  kind_o,
  input wire logic [7:0]  data_byte_o,
  input wire logic        link_valid_o,
  input wire logic [31:0] src_addr_o,
  input wire logic [15:0] peer_port_o,
  input wire logic [15:0] frame_len_o,
  input wire logic        last_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a full table reports nothing else
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ipdp_pkg::KIND_TABLE_FULL |->
      !link_valid_o && src_addr_o == 32'd0 && peer_port_o == 16'd0 && !last_o)
    else $error("table full result carries data");

  // empty frame is a single closing result
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ipdp_pkg::KIND_EMPTY |->
      last_o && data_byte_o == 8'd0 && frame_len_o == 16'd0)
    else $error("empty frame result malformed");

  // unknown link never leaks table contents
  a_bad_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !link_valid_o |-> src_addr_o == 32'd0 && peer_port_o == 16'd0)
    else $error("table data on invalid link");

  // registration results are never part of a frame
  a_reg_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ipdp_pkg::KIND_LINK_REG |->
      link_valid_o && !last_o && frame_len_o == 16'd0)
    else $error("registration result malformed");

endmodule

bind at_ipd_frame_parser_core ipdp_checker u_ipdp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_o       (kind_o),
  .data_byte_o  (data_byte_o),
  .link_valid_o (link_valid_o),
  .src_addr_o   (src_addr_o),
  .peer_port_o  (peer_port_o),
  .frame_len_o  (frame_len_o),
  .last_o       (last_o)
);

`default_nettype wire
